/* sv/hpt_pkg.sv */
// Shared types, constants and the angle wrap function of the heading PID turn block.
`default_nettype none

package hpt_pkg;

  localparam int unsigned HALF_TURN = 18000;
  localparam int unsigned FULL_TURN = 36000;

  // Full turn = 1125 * 2^5, so the gain divisor splits into a shift and a divide by 1125.
  localparam int unsigned DIV_POW     = 5;
  localparam int unsigned DIV_ODD     = 1125;
  localparam int unsigned QIN_W       = 26;
  localparam int unsigned RECIP_W     = 27;
  localparam int unsigned RECIP_SHIFT = 37;
  localparam logic [RECIP_W-1:0] RECIP = 27'd122167959;  // ceil(2^37 / 1125)
  localparam int unsigned Q_W         = 16;

  localparam logic [14:0] LIMIT_MAX  = 15'h7FFF;
  localparam logic [2:0]  SETTLE_MAX = 3'd7;

  localparam logic [14:0] START_LIMIT_RST    = 15'd100;
  localparam logic [9:0]  LIMIT_STEP_RST     = 10'd6;
  localparam logic [14:0] SETTLE_BAND_RST    = 15'd100;
  localparam logic [2:0]  SETTLE_SAMPLES_RST = 3'd5;

  typedef enum logic [2:0] {
    REG_TARGET_HEADING = 3'd0,
    REG_GAIN_P         = 3'd1,
    REG_GAIN_D         = 3'd2,
    REG_GAIN_I         = 3'd3,
    REG_START_LIMIT    = 3'd4,
    REG_LIMIT_STEP     = 3'd5,
    REG_SETTLE_BAND    = 3'd6,
    REG_SETTLE_SAMPLES = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] target_heading;
    logic [15:0] gain_p;
    logic [15:0] gain_d;
    logic [15:0] gain_i;
    logic [14:0] start_limit;
    logic [9:0]  limit_step;
    logic [14:0] settle_band;
    logic [2:0]  settle_samples;
  } cfg_t;

  // Per-item side info that rides along the arithmetic pipeline.
  typedef struct packed {
    logic [14:0] limit;    // clamp magnitude for this tick
    logic        settled;  // turn finished at or before this tick
    logic        hold;     // turn already finished: force drive to zero
  } side_t;

  // Wrap a heading difference (-65535..65535) to -18000..17999.
  function automatic logic signed [15:0] wrap_angle(input logic signed [17:0] diff);
    logic signed [17:0] x;
    logic signed [17:0] y;
    x = diff + 18'sd18000;
    if (x >= 18'sd72000) begin
      y = x - 18'sd72000;
    end else if (x >= 18'sd36000) begin
      y = x - 18'sd36000;
    end else if (x >= 18'sd0) begin
      y = x;
    end else if (x >= -18'sd36000) begin
      y = x + 18'sd36000;
    end else begin
      y = x + 18'sd72000;
    end
    y = y - 18'sd18000;
    return y[15:0];
  endfunction

endpackage

`default_nettype wire

/* sv/hpt_err.sv */
// Input stage: register the wrapped heading error and the start flag of each beat.
`default_nettype none

module hpt_err (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire logic [15:0]        heading_i,
  input  wire logic               start_i,
  input  wire logic [15:0]        target_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output logic signed [15:0]      err_o,
  output logic                    start_o
);

  logic              valid_q, valid_d;
  logic              en;
  logic signed [15:0] err_q;
  logic              start_q;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;
  assign valid_d = en ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      err_q   <= hpt_pkg::wrap_angle($signed({2'b00, target_i}) - $signed({2'b00, heading_i}));
      start_q <= start_i;
    end
  end

  assign valid_o = valid_q;
  assign err_o   = err_q;
  assign start_o = start_q;

endmodule

`default_nettype wire

/* sv/hpt_state.sv */
// Loop state: error history, saturating integral, clamp ramp and settle tracking.
`default_nettype none

module hpt_state #(
  parameter int unsigned SUM_WIDTH = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire hpt_pkg::cfg_t         cfg_i,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire logic signed [15:0]    err_i,
  input  wire logic                  start_i,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output logic signed [15:0]         err_o,
  output logic signed [15:0]         derr_o,
  output logic signed [SUM_WIDTH-1:0] sum_o,
  output hpt_pkg::side_t             side_o
);

  logic                       valid_q, valid_d;
  logic                       en, take;
  logic signed [15:0]         last_q;
  logic signed [SUM_WIDTH-1:0] sum_q, sum_d;
  logic [14:0]                limit_q, limit_d;
  logic [2:0]                 cnt_q, cnt_d;
  logic                       fin_q, fin_d;

  logic signed [15:0]         derr;
  logic signed [SUM_WIDTH:0]  sum_ext;
  logic [15:0]                err_abs;
  logic [15:0]                limit_sum;

  logic signed [15:0]         err_oq, derr_oq;
  logic signed [SUM_WIDTH-1:0] sum_oq;
  hpt_pkg::side_t             side_oq;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;
  assign take    = en && valid_i;

  always_comb begin
    derr    = hpt_pkg::wrap_angle($signed({{2{err_i[15]}}, err_i}) -
                                  $signed({{2{last_q[15]}}, last_q}));
    sum_ext = $signed({sum_q[SUM_WIDTH-1], sum_q}) + (SUM_WIDTH+1)'(err_i);
    err_abs = err_i[15] ? 16'(-err_i) : 16'(err_i);
    limit_sum = {1'b0, limit_q} + {6'b0, cfg_i.limit_step};

    sum_d   = sum_q;
    limit_d = limit_q;
    cnt_d   = cnt_q;
    fin_d   = fin_q;
    valid_d = en ? 1'b0 : valid_q;

    if (take) begin
      if (start_i) begin
        sum_d   = '0;
        limit_d = cfg_i.start_limit;
        cnt_d   = '0;
        fin_d   = 1'b0;
      end else if (fin_q) begin
        valid_d = 1'b1;
      end else begin
        valid_d = 1'b1;
        // Saturate the integral at the signed bounds.
        if (sum_ext[SUM_WIDTH] != sum_ext[SUM_WIDTH-1]) begin
          sum_d = sum_ext[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
                                     : {1'b0, {(SUM_WIDTH-1){1'b1}}};
        end else begin
          sum_d = sum_ext[SUM_WIDTH-1:0];
        end
        if (err_abs[14:0] < cfg_i.settle_band) begin
          cnt_d = (cnt_q == hpt_pkg::SETTLE_MAX) ? cnt_q : cnt_q + 3'd1;
        end else begin
          cnt_d = '0;
        end
        fin_d   = (cnt_d >= cfg_i.settle_samples);
        limit_d = limit_sum[15] ? hpt_pkg::LIMIT_MAX : limit_sum[14:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      last_q  <= '0;
      sum_q   <= '0;
      limit_q <= hpt_pkg::START_LIMIT_RST;
      cnt_q   <= '0;
      fin_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      sum_q   <= sum_d;
      limit_q <= limit_d;
      cnt_q   <= cnt_d;
      fin_q   <= fin_d;
      if (take && (start_i || !fin_q)) begin
        last_q <= err_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      err_oq          <= err_i;
      derr_oq         <= derr;
      sum_oq          <= sum_d;
      side_oq.limit   <= limit_q;
      side_oq.settled <= fin_d;
      side_oq.hold    <= fin_q;
    end
  end

  assign valid_o = valid_q;
  assign err_o   = err_oq;
  assign derr_o  = derr_oq;
  assign sum_o   = sum_oq;
  assign side_o  = side_oq;

endmodule

`default_nettype wire

/* sv/hpt_mac.sv */
// Gain products and their sum over three register stages.
`default_nettype none

module hpt_mac #(
  parameter int unsigned SUM_WIDTH = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire hpt_pkg::cfg_t          cfg_i,
  input  wire logic                   valid_i,
  output logic                        ready_o,
  input  wire logic signed [15:0]     err_i,
  input  wire logic signed [15:0]     derr_i,
  input  wire logic signed [SUM_WIDTH-1:0] sum_i,
  input  wire hpt_pkg::side_t         side_i,
  output logic                        valid_o,
  input  wire logic                   ready_i,
  output logic signed [SUM_WIDTH+17:0] acc_o,
  output hpt_pkg::side_t              side_o
);

  localparam int unsigned ACC_W = SUM_WIDTH + 18;
  localparam int unsigned LO_W  = SUM_WIDTH / 2;
  localparam int unsigned HI_W  = SUM_WIDTH - LO_W;

  logic [2:0] valid_q, valid_d;
  logic [2:0] en;

  // stage A: products
  logic signed [32:0]        pp_q, pd_q;
  logic signed [LO_W+17:0]   plo_q;
  logic signed [HI_W+16:0]   phi_q;
  hpt_pkg::side_t            side_a_q;
  // stage B: partial sums
  logic signed [33:0]        pdsum_q;
  logic signed [ACC_W-1:0]   isum_q;
  hpt_pkg::side_t            side_b_q;
  // stage C: accumulator
  logic signed [ACC_W-1:0]   acc_q;
  hpt_pkg::side_t            side_c_q;

  assign en[2]   = !valid_q[2] || ready_i;
  assign en[1]   = !valid_q[1] || en[2];
  assign en[0]   = !valid_q[0] || en[1];
  assign ready_o = en[0];

  assign valid_d[0] = en[0] ? valid_i    : valid_q[0];
  assign valid_d[1] = en[1] ? valid_q[0] : valid_q[1];
  assign valid_d[2] = en[2] ? valid_q[1] : valid_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && valid_i) begin
      pp_q     <= $signed({1'b0, cfg_i.gain_p}) * err_i;
      pd_q     <= $signed({1'b0, cfg_i.gain_d}) * derr_i;
      plo_q    <= $signed({1'b0, cfg_i.gain_i}) * $signed({1'b0, sum_i[LO_W-1:0]});
      phi_q    <= $signed({1'b0, cfg_i.gain_i}) * $signed(sum_i[SUM_WIDTH-1:LO_W]);
      side_a_q <= side_i;
    end
    if (en[1] && valid_q[0]) begin
      pdsum_q  <= 34'(pp_q) + 34'(pd_q);
      isum_q   <= (ACC_W'(phi_q) <<< LO_W) + ACC_W'(plo_q);
      side_b_q <= side_a_q;
    end
    if (en[2] && valid_q[1]) begin
      acc_q    <= ACC_W'(pdsum_q) + isum_q;
      side_c_q <= side_b_q;
    end
  end

  assign valid_o = valid_q[2];
  assign acc_o   = acc_q;
  assign side_o  = side_c_q;

endmodule

`default_nettype wire

/* sv/hpt_scale.sv */
// Divide the accumulator by the full-turn gain scale, truncate toward zero and clamp.
`default_nettype none

module hpt_scale #(
  parameter int unsigned SUM_WIDTH      = 32,
  parameter int unsigned GAIN_FRAC_BITS = 8
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    valid_i,
  output logic                         ready_o,
  input  wire logic signed [SUM_WIDTH+17:0] acc_i,
  input  wire hpt_pkg::side_t          side_i,
  output logic                         valid_o,
  input  wire logic                    ready_i,
  output logic signed [15:0]           drive_o,
  output logic                         settled_o
);

  localparam int unsigned ACC_W  = SUM_WIDTH + 18;
  localparam int unsigned SHIFT  = hpt_pkg::DIV_POW + GAIN_FRAC_BITS;
  localparam int unsigned QIN_W  = hpt_pkg::QIN_W;
  localparam int unsigned PROD_W = hpt_pkg::QIN_W + hpt_pkg::RECIP_W;
  localparam int unsigned Q_W    = hpt_pkg::Q_W;

  logic [2:0] valid_q, valid_d;
  logic [2:0] en;

  logic [ACC_W-1:0]  mag, shifted;
  logic [QIN_W-1:0]  m_q;
  logic              neg_a_q, neg_b_q;
  hpt_pkg::side_t    side_a_q, side_b_q;
  logic [PROD_W-1:0] prod_q;
  logic [Q_W-1:0]    quot, quot_c;
  logic signed [15:0] drive_d, drive_q;
  logic              settled_q;

  assign en[2]   = !valid_q[2] || ready_i;
  assign en[1]   = !valid_q[1] || en[2];
  assign en[0]   = !valid_q[0] || en[1];
  assign ready_o = en[0];

  assign valid_d[0] = en[0] ? valid_i    : valid_q[0];
  assign valid_d[1] = en[1] ? valid_q[0] : valid_q[1];
  assign valid_d[2] = en[2] ? valid_q[1] : valid_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Magnitude and power-of-two part of the divisor; anything past 2^26 clamps anyway.
  always_comb begin
    mag     = acc_i[ACC_W-1] ? ACC_W'(-acc_i) : ACC_W'(acc_i);
    shifted = mag >> SHIFT;
  end

  // Quotient by 1125 from the reciprocal product, then clamp and restore the sign.
  always_comb begin
    quot   = prod_q[hpt_pkg::RECIP_SHIFT +: Q_W];
    quot_c = (quot > {1'b0, side_b_q.limit}) ? {1'b0, side_b_q.limit} : quot;
    if (side_b_q.hold) begin
      drive_d = '0;
    end else if (neg_b_q) begin
      drive_d = $signed(-quot_c);
    end else begin
      drive_d = $signed(quot_c);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && valid_i) begin
      m_q      <= (|shifted[ACC_W-1:QIN_W]) ? {QIN_W{1'b1}} : shifted[QIN_W-1:0];
      neg_a_q  <= acc_i[ACC_W-1];
      side_a_q <= side_i;
    end
    if (en[1] && valid_q[0]) begin
      prod_q   <= PROD_W'(m_q) * PROD_W'(hpt_pkg::RECIP);
      neg_b_q  <= neg_a_q;
      side_b_q <= side_a_q;
    end
    if (en[2] && valid_q[1]) begin
      drive_q   <= drive_d;
      settled_q <= side_b_q.settled;
    end
  end

  assign valid_o   = valid_q[2];
  assign drive_o   = drive_q;
  assign settled_o = settled_q;

endmodule

`default_nettype wire

/* sv/heading_pid_turn.sv */
// Top level of the heading PID turn controller: config registers and pipeline.
//
//  channel  | dir | handshake                    | payload
//  ---------+-----+------------------------------+-----------------------------------
//  s_axis   | in  | s_axis_tvalid/s_axis_tready  | tdata: heading_sample, tuser: start_req
//  m_axis   | out | m_axis_tvalid/m_axis_tready  | tdata: drive, tuser: settled
//  cfg      | in  | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
// One beat per cycle in and out while m_axis does not stall: eight register stages (error, loop state, three MAC,
// three divide/clamp) lie between a tick's input beat and its result on m_axis.
// The loop state updates as it takes each beat, so ticks follow back to back; reset clears it
// and loads the register defaults. A stage holds its item only while the next one is
// full and stalled, so bubbles collapse. A start beat updates state and gives no
// result. Config writes are always ready and must only land while the pipeline is empty.
`default_nettype none

module heading_pid_turn #(
  parameter int unsigned GAIN_FRAC_BITS = 8,
  parameter int unsigned SUM_WIDTH      = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input samples
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] heading_sample
  input  wire logic [0:0]  s_axis_tuser,   // [0] start_req
  // results
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] drive (signed)
  output logic [0:0]       m_axis_tuser,   // [0] settled
  // register writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  hpt_pkg::cfg_t cfg_q;

  // register file: always ready, decode index on each write beat
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_heading <= '0;
      cfg_q.gain_p         <= '0;
      cfg_q.gain_d         <= '0;
      cfg_q.gain_i         <= '0;
      cfg_q.start_limit    <= hpt_pkg::START_LIMIT_RST;
      cfg_q.limit_step     <= hpt_pkg::LIMIT_STEP_RST;
      cfg_q.settle_band    <= hpt_pkg::SETTLE_BAND_RST;
      cfg_q.settle_samples <= hpt_pkg::SETTLE_SAMPLES_RST;
    end else if (cfg_valid_i) begin
      unique case (hpt_pkg::cfg_reg_e'(cfg_index_i))
        hpt_pkg::REG_TARGET_HEADING: cfg_q.target_heading <= cfg_data_i;
        hpt_pkg::REG_GAIN_P:         cfg_q.gain_p         <= cfg_data_i;
        hpt_pkg::REG_GAIN_D:         cfg_q.gain_d         <= cfg_data_i;
        hpt_pkg::REG_GAIN_I:         cfg_q.gain_i         <= cfg_data_i;
        hpt_pkg::REG_START_LIMIT:    cfg_q.start_limit    <= cfg_data_i[14:0];
        hpt_pkg::REG_LIMIT_STEP:     cfg_q.limit_step     <= cfg_data_i[9:0];
        hpt_pkg::REG_SETTLE_BAND:    cfg_q.settle_band    <= cfg_data_i[14:0];
        hpt_pkg::REG_SETTLE_SAMPLES: cfg_q.settle_samples <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // stage links
  logic                        err_valid, err_ready, err_start;
  logic signed [15:0]          err_err;
  logic                        st_valid, st_ready;
  logic signed [15:0]          st_err, st_derr;
  logic signed [SUM_WIDTH-1:0] st_sum;
  hpt_pkg::side_t              st_side;
  logic                        mac_valid, mac_ready;
  logic signed [SUM_WIDTH+17:0] mac_acc;
  hpt_pkg::side_t              mac_side;
  logic signed [15:0]          drive;
  logic                        settled;

  // wrap target minus heading into the error register
  hpt_err u_err (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .heading_i (s_axis_tdata),
    .start_i   (s_axis_tuser[0]),
    .target_i  (cfg_q.target_heading),
    .valid_o   (err_valid),
    .ready_i   (err_ready),
    .err_o     (err_err),
    .start_o   (err_start)
  );

  // advance loop state; drop start beats after loading the initial error
  hpt_state #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_state (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (err_valid),
    .ready_o (err_ready),
    .err_i   (err_err),
    .start_i (err_start),
    .valid_o (st_valid),
    .ready_i (st_ready),
    .err_o   (st_err),
    .derr_o  (st_derr),
    .sum_o   (st_sum),
    .side_o  (st_side)
  );

  // P*e + D*de + I*sum
  hpt_mac #(
    .SUM_WIDTH (SUM_WIDTH)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (st_valid),
    .ready_o (st_ready),
    .err_i   (st_err),
    .derr_i  (st_derr),
    .sum_i   (st_sum),
    .side_i  (st_side),
    .valid_o (mac_valid),
    .ready_i (mac_ready),
    .acc_o   (mac_acc),
    .side_o  (mac_side)
  );

  // scale, clamp and hold the result for m_axis
  hpt_scale #(
    .SUM_WIDTH      (SUM_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_scale (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (mac_valid),
    .ready_o   (mac_ready),
    .acc_i     (mac_acc),
    .side_i    (mac_side),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .drive_o   (drive),
    .settled_o (settled)
  );

  assign m_axis_tdata    = drive;
  assign m_axis_tuser[0] = settled;

endmodule

`default_nettype wire
